// File: rtl/rit_pkg.sv
// Shared types and codes for the range increment / mod-3 count tree.
package rit_pkg;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_COUNT = 1'b1;

	localparam logic REG_ACTIVE_LENGTH = 1'b0;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_CLR_INIT,
		OP_CLR_STEP,
		OP_LOAD,
		OP_DOWN_INIT,
		OP_RD_PARENT,
		OP_CAP_PARENT,
		OP_WR_CHILD0,
		OP_WR_CHILD1,
		OP_WR_PARENT,
		OP_BU_INIT,
		OP_BU_LEFT_RD,
		OP_BU_LEFT_APPLY,
		OP_BU_RIGHT_RD,
		OP_BU_RIGHT_APPLY,
		OP_BU_SHIFT,
		OP_UP_INIT,
		OP_RB_RD0,
		OP_RB_RD1,
		OP_RB_RDP,
		OP_RB_WR
	} rit_op_t;

	typedef struct packed {
		rit_op_t op;
		logic    path;
	} rit_ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic is_count;
		logic tag_zero;
		logic sh_last;
		logic sh_top;
		logic path;
		logic lr_lt;
		logic l_odd;
		logic r_odd;
	} rit_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_LOAD,
		ST_PR,
		ST_PD,
		ST_CD0,
		ST_CD1,
		ST_PW,
		ST_PINIT1,
		ST_BINIT,
		ST_BL,
		ST_BLD,
		ST_BR,
		ST_BRD,
		ST_BS,
		ST_RINIT0,
		ST_RINIT1,
		ST_RR0,
		ST_RD0,
		ST_RD1,
		ST_RDP,
		ST_DONE
	} rit_state_t;

endpackage

// File: rtl/rit_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rit_datapath.sv
// Datapath: node store, path and range registers, node update and count accumulation.
module rit_datapath
	import rit_pkg::*;
#(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rit_ctrl_t                         ctrl,
	output rit_stat_t                         stat,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0] len,
	input  logic                              cmd,
	input  logic [15:0]                       range_low,
	input  logic [15:0]                       range_high,
	output logic [16:0]                       multiple_count
);

	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int AW = IW + 1;
	localparam int CW = IW + 1;
	localparam int RW = 2 + 3 * CW;
	localparam int SW = $clog2(IW + 1);
	localparam int N  = 1 << IW;

	function automatic logic [RW-1:0] shift_node(input logic [RW-1:0] n, input logic [1:0] s,
			input logic internal);
		logic [CW-1:0] c0;
		logic [CW-1:0] c1;
		logic [CW-1:0] c2;
		logic [1:0]    t;
		logic [2:0]    ts;
		logic [1:0]    nt;
		logic [RW-1:0] res;
		c0 = n[CW-1:0];
		c1 = n[2*CW-1:CW];
		c2 = n[3*CW-1:2*CW];
		t  = n[RW-1:RW-2];
		ts = {1'b0, t} + {1'b0, s};
		if (ts >= 3'd3) begin
			ts = ts - 3'd3;
		end
		nt = internal ? ts[1:0] : t;
		case (s)
			2'd1:    res = {nt, c1, c0, c2};
			2'd2:    res = {nt, c0, c2, c1};
			default: res = {nt, c2, c1, c0};
		endcase
		return res;
	endfunction

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;

	logic [AW-1:0] clr_addr_q;
	logic [CW-1:0] size_q;
	logic [IW-1:0] a_q, bb_q;
	logic          cmd_q, empty_q, path_q;
	logic [SW-1:0] sh_q;
	logic [RW-1:0] rec_q;
	logic [AW:0]   l_q, r_q;
	logic [CW-1:0] acc_q;

	logic [AW-1:0] leaf, p, c0a, c1a;
	logic [31:0]   lm1, bv, bb32;
	logic [1:0]    rtag;

	rit_ram #(.W(RW), .D(1 << AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign leaf = {1'b1, (path_q ? bb_q : a_q)};
	assign p    = AW'(leaf >> sh_q);
	assign c0a  = {p[AW-2:0], 1'b0};
	assign c1a  = {p[AW-2:0], 1'b1};
	assign rtag = rec_q[RW-1:RW-2];

	assign lm1  = 32'(len) - 32'd1;
	assign bv   = 32'(range_high);
	assign bb32 = (bv < lm1) ? bv : lm1;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		case (ctrl.op)
			OP_CLR_STEP: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = RW'(size_q);
			end
			OP_RD_PARENT, OP_RB_RDP: begin
				re    = 1'b1;
				raddr = p;
			end
			OP_CAP_PARENT, OP_RB_RD0: begin
				re    = 1'b1;
				raddr = c0a;
			end
			OP_WR_CHILD0: begin
				we    = 1'b1;
				waddr = c0a;
				wdata = shift_node(rdata, rtag, sh_q != SW'(1));
				re    = 1'b1;
				raddr = c1a;
			end
			OP_WR_CHILD1: begin
				we    = 1'b1;
				waddr = c1a;
				wdata = shift_node(rdata, rtag, sh_q != SW'(1));
			end
			OP_WR_PARENT: begin
				we    = 1'b1;
				waddr = p;
				wdata = {2'd0, rec_q[3*CW-1:0]};
			end
			OP_RB_RD1: begin
				re    = 1'b1;
				raddr = c1a;
			end
			OP_RB_WR: begin
				we    = 1'b1;
				waddr = p;
				wdata = shift_node({rdata[RW-1:RW-2], rec_q[3*CW-1:0]}, rdata[RW-1:RW-2], 1'b0);
			end
			OP_BU_LEFT_RD: begin
				re    = 1'b1;
				raddr = l_q[AW-1:0];
			end
			OP_BU_RIGHT_RD: begin
				re    = 1'b1;
				raddr = AW'(r_q - (AW+1)'(1));
			end
			OP_BU_LEFT_APPLY: begin
				we    = cmd_q == CMD_ADD;
				waddr = l_q[AW-1:0];
				wdata = shift_node(rdata, 2'd1, l_q < (AW+1)'(N));
			end
			OP_BU_RIGHT_APPLY: begin
				we    = cmd_q == CMD_ADD;
				waddr = r_q[AW-1:0];
				wdata = shift_node(rdata, 2'd1, r_q < (AW+1)'(N));
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '1;
			size_q     <= CW'(1);
			path_q     <= 1'b0;
			sh_q       <= '0;
			cmd_q      <= CMD_ADD;
			empty_q    <= 1'b1;
			acc_q      <= '0;
			l_q        <= '0;
			r_q        <= '0;
		end else begin
			case (ctrl.op)
				OP_CLR_INIT: begin
					clr_addr_q <= '1;
					size_q     <= CW'(1);
				end
				OP_CLR_STEP: begin
					clr_addr_q <= clr_addr_q - AW'(1);
					if ((clr_addr_q & (clr_addr_q - AW'(1))) == '0) begin
						size_q <= {size_q[CW-2:0], 1'b0};
					end
				end
				OP_LOAD: begin
					cmd_q   <= cmd;
					empty_q <= 32'(range_low) > bb32;
					acc_q   <= '0;
				end
				OP_DOWN_INIT: begin
					path_q <= ctrl.path;
					sh_q   <= SW'(IW);
				end
				OP_UP_INIT: begin
					path_q <= ctrl.path;
					sh_q   <= SW'(1);
				end
				OP_CAP_PARENT: begin
					if (rdata[RW-1:RW-2] == 2'd0) begin
						sh_q <= sh_q - SW'(1);
					end
				end
				OP_WR_PARENT: sh_q <= sh_q - SW'(1);
				OP_RB_WR:     sh_q <= sh_q + SW'(1);
				OP_BU_INIT: begin
					l_q <= {1'b0, 1'b1, a_q};
					r_q <= {1'b0, 1'b1, bb_q} + (AW+1)'(1);
				end
				OP_BU_LEFT_APPLY: begin
					l_q <= l_q + (AW+1)'(1);
					if (cmd_q == CMD_COUNT) begin
						acc_q <= acc_q + rdata[CW-1:0];
					end
				end
				OP_BU_RIGHT_RD: r_q <= r_q - (AW+1)'(1);
				OP_BU_RIGHT_APPLY: begin
					if (cmd_q == CMD_COUNT) begin
						acc_q <= acc_q + rdata[CW-1:0];
					end
				end
				OP_BU_SHIFT: begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
				default: begin
					path_q <= path_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				a_q  <= IW'(range_low);
				bb_q <= IW'(bb32);
			end
			OP_CAP_PARENT, OP_RB_RD1: rec_q <= rdata;
			OP_RB_RDP: begin
				rec_q[CW-1:0]      <= rec_q[CW-1:0] + rdata[CW-1:0];
				rec_q[2*CW-1:CW]   <= rec_q[2*CW-1:CW] + rdata[2*CW-1:CW];
				rec_q[3*CW-1:2*CW] <= rec_q[3*CW-1:2*CW] + rdata[3*CW-1:2*CW];
			end
			default: begin
				rec_q <= rec_q;
			end
		endcase
	end

	assign stat.clr_last = clr_addr_q == AW'(1);
	assign stat.empty    = empty_q;
	assign stat.is_count = cmd_q == CMD_COUNT;
	assign stat.tag_zero = rdata[RW-1:RW-2] == 2'd0;
	assign stat.sh_last  = sh_q == SW'(1);
	assign stat.sh_top   = sh_q == SW'(IW);
	assign stat.path     = path_q;
	assign stat.lr_lt    = l_q < r_q;
	assign stat.l_odd    = l_q[0];
	assign stat.r_odd    = r_q[0];

	assign multiple_count = 17'(acc_q);

endmodule

// File: rtl/rit_ctrl.sv
// Controller: sequences clearing, push-down, range walk and rebuild.
module rit_ctrl
	import rit_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      clr_req,
	input  rit_stat_t stat,
	output rit_ctrl_t ctrl,
	output logic      busy,
	output logic      done
);

	rit_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl.op   = OP_IDLE;
		ctrl.path = 1'b0;
		busy      = (state_q != ST_IDLE) || clr_req;
		done      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (clr_req) begin
					ctrl.op = OP_CLR_INIT;
					state_d = ST_CLR;
				end else if (start) begin
					ctrl.op = OP_LOAD;
					state_d = ST_LOAD;
				end
			end
			ST_CLR: begin
				ctrl.op = OP_CLR_STEP;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				ctrl.op = OP_DOWN_INIT;
				state_d = stat.empty ? ST_DONE : ST_PR;
			end
			ST_PR: begin
				ctrl.op = OP_RD_PARENT;
				state_d = ST_PD;
			end
			ST_PD: begin
				ctrl.op = OP_CAP_PARENT;
				if (!stat.tag_zero) begin
					state_d = ST_CD0;
				end else if (!stat.sh_last) begin
					state_d = ST_PR;
				end else begin
					state_d = stat.path ? ST_BINIT : ST_PINIT1;
				end
			end
			ST_CD0: begin
				ctrl.op = OP_WR_CHILD0;
				state_d = ST_CD1;
			end
			ST_CD1: begin
				ctrl.op = OP_WR_CHILD1;
				state_d = ST_PW;
			end
			ST_PW: begin
				ctrl.op = OP_WR_PARENT;
				if (!stat.sh_last) begin
					state_d = ST_PR;
				end else begin
					state_d = stat.path ? ST_BINIT : ST_PINIT1;
				end
			end
			ST_PINIT1: begin
				ctrl.op   = OP_DOWN_INIT;
				ctrl.path = 1'b1;
				state_d   = ST_PR;
			end
			ST_BINIT: begin
				ctrl.op = OP_BU_INIT;
				state_d = ST_BL;
			end
			ST_BL: begin
				if (!stat.lr_lt) begin
					state_d = stat.is_count ? ST_DONE : ST_RINIT0;
				end else if (stat.l_odd) begin
					ctrl.op = OP_BU_LEFT_RD;
					state_d = ST_BLD;
				end else begin
					state_d = ST_BR;
				end
			end
			ST_BLD: begin
				ctrl.op = OP_BU_LEFT_APPLY;
				state_d = ST_BR;
			end
			ST_BR: begin
				if (stat.r_odd) begin
					ctrl.op = OP_BU_RIGHT_RD;
					state_d = ST_BRD;
				end else begin
					ctrl.op = OP_BU_SHIFT;
					state_d = ST_BL;
				end
			end
			ST_BRD: begin
				ctrl.op = OP_BU_RIGHT_APPLY;
				state_d = ST_BS;
			end
			ST_BS: begin
				ctrl.op = OP_BU_SHIFT;
				state_d = ST_BL;
			end
			ST_RINIT0: begin
				ctrl.op = OP_UP_INIT;
				state_d = ST_RR0;
			end
			ST_RINIT1: begin
				ctrl.op   = OP_UP_INIT;
				ctrl.path = 1'b1;
				state_d   = ST_RR0;
			end
			ST_RR0: begin
				ctrl.op = OP_RB_RD0;
				state_d = ST_RD0;
			end
			ST_RD0: begin
				ctrl.op = OP_RB_RD1;
				state_d = ST_RD1;
			end
			ST_RD1: begin
				ctrl.op = OP_RB_RDP;
				state_d = ST_RDP;
			end
			ST_RDP: begin
				ctrl.op = OP_RB_WR;
				if (!stat.sh_top) begin
					state_d = ST_RR0;
				end else begin
					state_d = stat.path ? ST_DONE : ST_RINIT1;
				end
			end
			ST_DONE: begin
				done    = stat.is_count;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/range_increment_mod3_count_tree.sv
// Top level: register port, controller and datapath of the mod-3 count tree.
//
// Commands enter on start with cmd, range_low and range_high; an item is taken
// when start is high and busy is low. cmd add increments every element in the
// range and gives no result; cmd count returns multiple_count with done high
// for one cycle. The receiver cannot stall; each result is shown once.
// Ranges are clipped to active_length; a reversed range adds nothing / counts 0.
// An item takes two root-to-leaf push-down walks, a bottom-up range walk and,
// for adds, two rebuild walks of the node memory. Items are handled one at a
// time. After reset, and after a write of active_length while idle, a clearing
// pass over node addresses 2*N-1 down to 1 rebuilds the tree (N = MAX_ELEMENTS
// rounded up to a power of two); busy stays high meanwhile.
// active_length sits at byte address 0 of the register port; it resets to
// 65536 (limited to MAX_ELEMENTS), a write of 0 reads back as 1.
module range_increment_mod3_count_tree
	import rit_pkg::*;
#(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [15:0] range_low,
	input  logic [15:0] range_high,
	output logic        done,
	output logic [16:0] multiple_count
);

	localparam int LW        = $clog2(MAX_ELEMENTS + 1);
	localparam int RESET_LEN = (MAX_ELEMENTS < 65536) ? MAX_ELEMENTS : 65536;

	logic [LW-1:0] len_q;
	logic [31:0]   wv;
	logic          wr_hit;
	rit_ctrl_t     ctrl;
	rit_stat_t     stat;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_LENGTH);
	assign wv     = {15'd0, pwdata[16:0]};
	assign prdata = (paddr[2] == REG_ACTIVE_LENGTH) ? 32'(len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(RESET_LEN);
		end else if (wr_hit) begin
			if (wv == 32'd0) begin
				len_q <= LW'(1);
			end else if (wv > 32'(MAX_ELEMENTS)) begin
				len_q <= LW'(MAX_ELEMENTS);
			end else begin
				len_q <= LW'(wv);
			end
		end
	end

	rit_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.clr_req(wr_hit),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	rit_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.len           (len_q),
		.cmd           (cmd),
		.range_low     (range_low),
		.range_high    (range_high),
		.multiple_count(multiple_count)
	);

endmodule
